/* rtl/svbu_pkg.sv */
`timescale 1ns / 1ps
package svbu_pkg;

  localparam int PTR_W = 16;
  localparam int IDX_W = 10;
  localparam int VAL_W = 8;
  localparam int UA_W  = 2;

  // operation codes
  localparam logic [3:0] OP_SKIP      = 4'd0;
  localparam logic [3:0] OP_END       = 4'd1;
  localparam logic [3:0] OP_GOTO      = 4'd2;
  localparam logic [3:0] OP_IF_NZ     = 4'd3;
  localparam logic [3:0] OP_IF_CMP    = 4'd4;
  localparam logic [3:0] OP_SET_ONE   = 4'd5;
  localparam logic [3:0] OP_CLEAR     = 4'd6;
  localparam logic [3:0] OP_INC       = 4'd7;
  localparam logic [3:0] OP_DEC       = 4'd8;
  localparam logic [3:0] OP_SET_VAL   = 4'd9;
  localparam logic [3:0] OP_CLEAR_ALL = 4'd10;
  localparam logic [3:0] OP_IF_INPUT  = 4'd11;

  // compare codes
  localparam logic [2:0] CMP_EQ = 3'd0;
  localparam logic [2:0] CMP_LT = 3'd1;
  localparam logic [2:0] CMP_LE = 3'd2;
  localparam logic [2:0] CMP_GT = 3'd3;
  localparam logic [2:0] CMP_GE = 3'd4;
  localparam logic [2:0] CMP_NE = 3'd5;

  localparam logic [VAL_W-1:0] VAL_MAX = 8'd255;

  // microcode addresses
  localparam logic [UA_W-1:0] UA_FETCH = 2'd0;
  localparam logic [UA_W-1:0] UA_EXEC  = 2'd1;
  localparam logic [UA_W-1:0] UA_CLEAR = 2'd2;

  // jump conditions
  localparam logic [1:0] JC_ALWAYS   = 2'd0;
  localparam logic [1:0] JC_CLR_ALL  = 2'd1;
  localparam logic [1:0] JC_CLR_LAST = 2'd2;

  typedef struct packed {
    logic            take_in;
    logic            exec;
    logic            clear;
    logic [1:0]      cond;
    logic [UA_W-1:0] jt;
    logic [UA_W-1:0] jf;
  } ucode_t;

  typedef struct packed {
    logic             taken;
    logic             keep;
    logic             wr_en;
    logic             clr_all;
    logic [VAL_W-1:0] value;
    logic [PTR_W-1:0] pointer;
  } exec_res_t;

  function automatic ucode_t ucode_rom(input logic [UA_W-1:0] addr);
    ucode_t w;
    w = '0;
    case (addr)
      UA_FETCH: begin
        w.take_in = 1'b1;
        w.cond    = JC_ALWAYS;
        w.jt      = UA_EXEC;
        w.jf      = UA_EXEC;
      end
      UA_EXEC: begin
        w.exec = 1'b1;
        w.cond = JC_CLR_ALL;
        w.jt   = UA_CLEAR;
        w.jf   = UA_FETCH;
      end
      UA_CLEAR: begin
        w.clear = 1'b1;
        w.cond  = JC_CLR_LAST;
        w.jt    = UA_FETCH;
        w.jf    = UA_CLEAR;
      end
      default: begin
        w.cond = JC_ALWAYS;
        w.jt   = UA_FETCH;
        w.jf   = UA_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/svbu_cmd_if.sv */
`timescale 1ns / 1ps
interface svbu_cmd_if
  import svbu_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [3:0]       operation;
  logic [IDX_W-1:0] var_index;
  logic [2:0]       compare_op;
  logic [VAL_W-1:0] operand_value;
  logic [PTR_W-1:0] jump_offset;
  logic [3:0]       args_len;
  logic [7:0]       input_mask;
  logic [7:0]       joypad;

  modport source (
    output valid, operation, var_index, compare_op, operand_value, jump_offset,
           args_len, input_mask, joypad,
    input  ready
  );
  modport sink (
    input  valid, operation, var_index, compare_op, operand_value, jump_offset,
           args_len, input_mask, joypad,
    output ready
  );
endinterface

/* rtl/svbu_res_if.sv */
`timescale 1ns / 1ps
interface svbu_res_if
  import svbu_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [PTR_W-1:0] next_pointer;
  logic             branch_taken;
  logic             keep_running;
  logic [VAL_W-1:0] var_value;

  modport source (
    output valid, next_pointer, branch_taken, keep_running, var_value,
    input  ready
  );
  modport sink (
    input  valid, next_pointer, branch_taken, keep_running, var_value,
    output ready
  );
endinterface

/* rtl/svbu_cfg_if.sv */
`timescale 1ns / 1ps
interface svbu_cfg_if
  import svbu_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [PTR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* rtl/svbu_ram.sv */
`timescale 1ns / 1ps
module svbu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/svbu_exec.sv */
`timescale 1ns / 1ps
module svbu_exec
  import svbu_pkg::*;
(
  input  logic [3:0]       op,
  input  logic [2:0]       cmp,
  input  logic [VAL_W-1:0] cur,
  input  logic [VAL_W-1:0] operand,
  input  logic [7:0]       mask,
  input  logic [7:0]       joy,
  input  logic [PTR_W-1:0] ptr,
  input  logic [PTR_W-1:0] base,
  input  logic [PTR_W-1:0] offset,
  input  logic [3:0]       alen,
  output exec_res_t        res
);

  logic cmp_hit;
  logic ended;

  always_comb begin
    case (cmp)
      CMP_EQ:  cmp_hit = (cur == operand);
      CMP_LT:  cmp_hit = (cur < operand);
      CMP_LE:  cmp_hit = (cur <= operand);
      CMP_GT:  cmp_hit = (cur > operand);
      CMP_GE:  cmp_hit = (cur >= operand);
      CMP_NE:  cmp_hit = (cur != operand);
      default: cmp_hit = 1'b0;
    endcase
  end

  always_comb begin
    res.taken   = 1'b0;
    res.keep    = 1'b1;
    res.wr_en   = 1'b0;
    res.clr_all = 1'b0;
    res.value   = cur;
    ended       = 1'b0;
    case (op)
      OP_SKIP:     res.keep = 1'b0;
      OP_END: begin
        ended    = 1'b1;
        res.keep = 1'b0;
      end
      OP_GOTO:     res.taken = 1'b1;
      OP_IF_NZ:    res.taken = (cur != '0);
      OP_IF_CMP:   res.taken = cmp_hit;
      OP_SET_ONE: begin
        res.wr_en = 1'b1;
        res.value = VAL_W'(1);
      end
      OP_CLEAR: begin
        res.wr_en = 1'b1;
        res.value = '0;
      end
      OP_INC: begin
        res.wr_en = 1'b1;
        res.value = (cur == VAL_MAX) ? cur : cur + VAL_W'(1);
      end
      OP_DEC: begin
        res.wr_en = 1'b1;
        res.value = (cur == '0) ? cur : cur - VAL_W'(1);
      end
      OP_SET_VAL: begin
        res.wr_en = 1'b1;
        res.value = operand;
      end
      OP_CLEAR_ALL: begin
        res.clr_all = 1'b1;
        res.value   = '0;
      end
      OP_IF_INPUT: res.taken = ((joy & mask) != '0);
      default:     res.keep = 1'b0;
    endcase

    if (ended) begin
      res.pointer = '0;
    end else if (res.taken) begin
      res.pointer = base + offset;
    end else begin
      res.pointer = ptr + PTR_W'(1) + PTR_W'(alen);
    end
  end

endmodule

/* rtl/script_variable_branch_unit.sv */
`timescale 1ns / 1ps
// channel  dir  width           transfer when
// cmd      in   valid/ready     valid && ready: one script command
// res      out  valid/ready     valid && ready: pointer, flags, variable value
// cfg      in   valid/ready     valid && ready: script_base (16 bits), always ready
//
// a command runs as fetch (issue store read) then execute (read-modify-write)
// the single read port and the registered read of the variable store are why execute follows fetch
// clear_all runs the clearing pass, which writes one entry per cycle
// after reset the same clearing pass runs over every entry before cmd is ready
// execute waits while the result register holds an untaken result
module script_variable_branch_unit
  import svbu_pkg::*;
#(
  parameter int VAR_COUNT = 1024
) (
  input  logic clk,
  input  logic rst,
  svbu_cmd_if.sink   cmd,
  svbu_res_if.source res,
  svbu_cfg_if.sink   cfg
);

  localparam int AW       = $clog2(VAR_COUNT);
  localparam int IDX_SPAN = 1 << IDX_W;

  logic [UA_W-1:0]  upc;
  logic [UA_W-1:0]  upc_next;
  ucode_t           uw;
  logic             hold;
  logic             jump_hit;
  logic             in_fire;
  logic             exec_fire;
  logic             clr_last;
  logic [AW-1:0]    clr_cnt;

  logic [PTR_W-1:0] script_base;
  logic [PTR_W-1:0] script_pointer;

  logic [IDX_W-1:0] idx_red;
  logic [AW-1:0]    slot_in;

  logic [3:0]       lat_op;
  logic [AW-1:0]    lat_slot;
  logic [2:0]       lat_cmp;
  logic [VAL_W-1:0] lat_operand;
  logic [PTR_W-1:0] lat_offset;
  logic [3:0]       lat_alen;
  logic [7:0]       lat_mask;
  logic [7:0]       lat_joy;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [VAL_W-1:0] mem_rdata;

  exec_res_t        xr;

  // microcode sequencer
  assign uw        = ucode_rom(upc);
  assign cmd.ready = uw.take_in;
  assign in_fire   = cmd.valid && uw.take_in;
  assign exec_fire = uw.exec && (!res.valid || res.ready);
  assign clr_last  = (clr_cnt == AW'(VAR_COUNT - 1));
  assign hold      = (uw.take_in && !in_fire) || (uw.exec && !exec_fire);

  always_comb begin
    case (uw.cond)
      JC_ALWAYS:   jump_hit = 1'b1;
      JC_CLR_ALL:  jump_hit = xr.clr_all;
      JC_CLR_LAST: jump_hit = clr_last;
      default:     jump_hit = 1'b1;
    endcase
    if (hold) begin
      upc_next = upc;
    end else if (jump_hit) begin
      upc_next = uw.jt;
    end else begin
      upc_next = uw.jf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc     <= UA_CLEAR;
      clr_cnt <= '0;
    end else begin
      upc <= upc_next;
      if (uw.clear) begin
        clr_cnt <= clr_last ? '0 : clr_cnt + AW'(1);
      end
    end
  end

  // index reduction modulo VAR_COUNT, one compare-subtract per quotient bit
  always_comb begin
    idx_red = cmd.var_index;
    for (int k = 6; k >= 0; k--) begin
      if ((VAR_COUNT << k) < IDX_SPAN) begin
        if (32'(idx_red) >= (VAR_COUNT << k)) begin
          idx_red = idx_red - IDX_W'(VAR_COUNT << k);
        end
      end
    end
  end
  assign slot_in = AW'(idx_red);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      lat_op      <= cmd.operation;
      lat_slot    <= slot_in;
      lat_cmp     <= cmd.compare_op;
      lat_operand <= cmd.operand_value;
      lat_offset  <= cmd.jump_offset;
      lat_alen    <= cmd.args_len;
      lat_mask    <= cmd.input_mask;
      lat_joy     <= cmd.joypad;
    end
  end

  // variable store
  assign mem_raddr = uw.take_in ? slot_in : lat_slot;
  assign mem_we    = uw.clear || (exec_fire && xr.wr_en);
  assign mem_waddr = uw.clear ? clr_cnt : lat_slot;
  assign mem_wdata = uw.clear ? '0 : xr.value;

  svbu_ram #(
    .WIDTH (VAL_W),
    .DEPTH (VAR_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  svbu_exec u_exec (
    .op      (lat_op),
    .cmp     (lat_cmp),
    .cur     (mem_rdata),
    .operand (lat_operand),
    .mask    (lat_mask),
    .joy     (lat_joy),
    .ptr     (script_pointer),
    .base    (script_base),
    .offset  (lat_offset),
    .alen    (lat_alen),
    .res     (xr)
  );

  // configuration and pointer
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      script_base    <= '0;
      script_pointer <= '0;
    end else begin
      if (cfg.valid) begin
        script_base <= cfg.data;
      end
      if (exec_fire) begin
        script_pointer <= xr.pointer;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (exec_fire) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      res.next_pointer <= xr.pointer;
      res.branch_taken <= xr.taken;
      res.keep_running <= xr.keep;
      res.var_value    <= xr.value;
    end
  end

  a_no_cmd_in_clear: assert property (@(posedge clk) disable iff (rst)
    uw.clear |-> !cmd.ready)
    else $error("command accepted during clearing pass");

  a_clear_all_sweeps: assert property (@(posedge clk) disable iff (rst)
    (exec_fire && xr.clr_all) |=> (upc == UA_CLEAR && clr_cnt == '0))
    else $error("clear_all did not start a clearing pass");

  a_end_zero_ptr: assert property (@(posedge clk) disable iff (rst)
    (exec_fire && lat_op == OP_END) |=> (res.valid && res.next_pointer == '0))
    else $error("end did not zero the pointer");

  a_write_source: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (uw.clear || exec_fire))
    else $error("store written outside execute or clearing");

endmodule
